// ===== src/linear_key_value_table_unit_macros.svh =====
// Assertion macros for the linear key/value table unit.
// Used by the checker module; relies on clk and arst_n in the including scope.
`ifndef LINEAR_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_UNIT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define LKVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define LKVT_ASSERT_IMP(lbl, ante, cons, msg) \
	`LKVT_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LKVT_ASSERT_NXT(lbl, ante, cons, msg) \
	`LKVT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/lkvt_pkg.sv =====
// Package for the linear key/value table unit: sizes, command and status codes,
// and the per-cell control word. No dependencies.
package lkvt_pkg;

	localparam int DEPTH     = 128;
	localparam int WORD_BITS = 64;
	localparam int FIELD_W   = 64;
	localparam int ENTRY_W   = 8;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int GRP       = 16;
	localparam int NGRP      = (DEPTH + GRP - 1) / GRP;
	localparam int PFX_STEPS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic cmp;
		logic put;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== src/linear_key_value_table_unit.sv =====
// Linear key/value table unit: top level with command sequencer and the row of cells.
// Depends on lkvt_pkg, lkvt_cell and lkvt_select.
//
// A command word (op, key_word, value_word) is taken at a rising edge where start
// is high and busy is low. Each command gives one result word on status,
// found_value and entry_count, marked by done for exactly one cycle.
// Entries are kept oldest first in a row of cells; every cell compares its key
// with the command key at once, and a delete moves each cell above the removed
// entry down by one neighbor, all together.
// A put or clear passes through the compare state only, a delete through the
// compare and oldest-match prefix states, and a get through those and then the
// value reduction state. busy is high from the accepting edge until done shows,
// so a new command may be taken in the cycle that presents a result.
// Reset clears the entry count and the sequencer; stored words are not cleared
// and never read before they are written. The receiver cannot hold results off:
// each result is lost after its done cycle if not captured.
module linear_key_value_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [lkvt_pkg::FIELD_W-1:0] key_word,
	input  logic [lkvt_pkg::FIELD_W-1:0] value_word,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [lkvt_pkg::FIELD_W-1:0] found_value,
	output logic [lkvt_pkg::ENTRY_W-1:0] entry_count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PFX,
		S_RED
	} state_t;

	state_t                         state_q;
	lkvt_pkg::op_t                  op_q;
	logic [lkvt_pkg::WORD_BITS-1:0] key_q;
	logic [lkvt_pkg::WORD_BITS-1:0] value_q;
	logic [lkvt_pkg::CNT_W-1:0]     count_q;
	logic                           done_q;
	lkvt_pkg::status_t              status_q;
	logic [lkvt_pkg::WORD_BITS-1:0] found_q;
	logic [lkvt_pkg::ENTRY_W-1:0]   ecount_q;

	lkvt_pkg::cell_ctrl_t           ctrl [lkvt_pkg::DEPTH];
	logic [lkvt_pkg::WORD_BITS-1:0] cell_key [lkvt_pkg::DEPTH];
	logic [lkvt_pkg::WORD_BITS-1:0] cell_val [lkvt_pkg::DEPTH];
	logic [lkvt_pkg::DEPTH-1:0]     hit;
	logic [lkvt_pkg::DEPTH-1:0]     incl;
	logic                           any;
	logic                           any_q;
	logic [lkvt_pkg::WORD_BITS-1:0] sel_value;
	logic                           full;
	logic [lkvt_pkg::CNT_W-1:0]     count_inc;
	logic [lkvt_pkg::CNT_W-1:0]     count_dec;

	assign full      = (count_q == lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH));
	assign count_inc = count_q + lkvt_pkg::CNT_W'(1);
	assign count_dec = count_q - lkvt_pkg::CNT_W'(1);

	for (genvar i = 0; i < lkvt_pkg::DEPTH; i++) begin : g_cell
		logic [lkvt_pkg::WORD_BITS-1:0] nb_key;
		logic [lkvt_pkg::WORD_BITS-1:0] nb_val;

		if (i == lkvt_pkg::DEPTH - 1) begin : g_top
			assign nb_key = cell_key[i];
			assign nb_val = cell_val[i];
		end else begin : g_mid
			assign nb_key = cell_key[i+1];
			assign nb_val = cell_val[i+1];
		end

		assign ctrl[i].cmp   = (state_q == S_CMP);
		assign ctrl[i].put   = (state_q == S_CMP) && (op_q == lkvt_pkg::OP_PUT) && !full
			&& (count_q == lkvt_pkg::CNT_W'(i));
		assign ctrl[i].shift = (state_q == S_PFX) && (op_q == lkvt_pkg::OP_DELETE) && incl[i];

		lkvt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[i]),
			.valid     (lkvt_pkg::CNT_W'(i) < count_q),
			.cmd_key   (key_q),
			.cmd_value (value_q),
			.nb_key    (nb_key),
			.nb_value  (nb_val),
			.key_q     (cell_key[i]),
			.value_q   (cell_val[i]),
			.hit_q     (hit[i])
		);
	end

	lkvt_select u_select (
		.clk    (clk),
		.en     (state_q == S_PFX),
		.hit    (hit),
		.values (cell_val),
		.incl   (incl),
		.any    (any),
		.any_q  (any_q),
		.found  (sel_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= lkvt_pkg::OP_PUT;
			key_q    <= '0;
			value_q  <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= lkvt_pkg::ST_OK;
			found_q  <= '0;
			ecount_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= lkvt_pkg::op_t'(op);
						key_q   <= key_word[lkvt_pkg::WORD_BITS-1:0];
						value_q <= value_word[lkvt_pkg::WORD_BITS-1:0];
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					unique case (op_q)
						lkvt_pkg::OP_PUT: begin
							done_q  <= 1'b1;
							found_q <= '0;
							state_q <= S_IDLE;
							if (!full) begin
								count_q  <= count_inc;
								status_q <= lkvt_pkg::ST_OK;
								ecount_q <= lkvt_pkg::ENTRY_W'(count_inc);
							end else begin
								status_q <= lkvt_pkg::ST_FULL;
								ecount_q <= lkvt_pkg::ENTRY_W'(count_q);
							end
						end
						lkvt_pkg::OP_CLEAR: begin
							done_q   <= 1'b1;
							found_q  <= '0;
							count_q  <= '0;
							status_q <= lkvt_pkg::ST_OK;
							ecount_q <= '0;
							state_q  <= S_IDLE;
						end
						lkvt_pkg::OP_GET, lkvt_pkg::OP_DELETE: begin
							state_q <= S_PFX;
						end
					endcase
				end
				S_PFX: begin
					if (op_q == lkvt_pkg::OP_DELETE) begin
						done_q  <= 1'b1;
						found_q <= '0;
						state_q <= S_IDLE;
						if (any) begin
							count_q  <= count_dec;
							status_q <= lkvt_pkg::ST_OK;
							ecount_q <= lkvt_pkg::ENTRY_W'(count_dec);
						end else begin
							status_q <= lkvt_pkg::ST_NOT_FOUND;
							ecount_q <= lkvt_pkg::ENTRY_W'(count_q);
						end
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					done_q   <= 1'b1;
					ecount_q <= lkvt_pkg::ENTRY_W'(count_q);
					state_q  <= S_IDLE;
					if (any_q) begin
						status_q <= lkvt_pkg::ST_OK;
						found_q  <= sel_value;
					end else begin
						status_q <= lkvt_pkg::ST_NOT_FOUND;
						found_q  <= '0;
					end
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = lkvt_pkg::FIELD_W'(found_q);
	assign entry_count = ecount_q;

endmodule

// ===== src/lkvt_cell.sv =====
// One table cell: holds a key and a value, loads both from the command on a put, compares
// its key with the command key, and loads from its upper neighbor on a delete. Depends on lkvt_pkg.
module lkvt_cell (
	input  logic                           clk,
	input  lkvt_pkg::cell_ctrl_t           ctrl,
	input  logic                           valid,
	input  logic [lkvt_pkg::WORD_BITS-1:0] cmd_key,
	input  logic [lkvt_pkg::WORD_BITS-1:0] cmd_value,
	input  logic [lkvt_pkg::WORD_BITS-1:0] nb_key,
	input  logic [lkvt_pkg::WORD_BITS-1:0] nb_value,
	output logic [lkvt_pkg::WORD_BITS-1:0] key_q,
	output logic [lkvt_pkg::WORD_BITS-1:0] value_q,
	output logic                           hit_q
);

	always_ff @(posedge clk) begin
		if (ctrl.put) begin
			key_q   <= cmd_key;
			value_q <= cmd_value;
		end else if (ctrl.shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end
		if (ctrl.cmp) begin
			hit_q <= valid && (key_q == cmd_key);
		end
	end

endmodule

// ===== src/lkvt_select.sv =====
// Picks the oldest matching cell: prefix of the hit vector, delete shift mask,
// and a registered two-level value reduction. Depends on lkvt_pkg.
module lkvt_select (
	input  logic                           clk,
	input  logic                           en,
	input  logic [lkvt_pkg::DEPTH-1:0]     hit,
	input  logic [lkvt_pkg::WORD_BITS-1:0] values [lkvt_pkg::DEPTH],
	output logic [lkvt_pkg::DEPTH-1:0]     incl,
	output logic                           any,
	output logic                           any_q,
	output logic [lkvt_pkg::WORD_BITS-1:0] found
);

	logic [lkvt_pkg::DEPTH-1:0]     first;
	logic [lkvt_pkg::WORD_BITS-1:0] grp_d [lkvt_pkg::NGRP];
	logic [lkvt_pkg::WORD_BITS-1:0] grp_q [lkvt_pkg::NGRP];

	always_comb begin
		logic [lkvt_pkg::DEPTH-1:0] v;
		v = hit;
		for (int s = 0; s < lkvt_pkg::PFX_STEPS; s++) begin
			v = v | (v << (1 << s));
		end
		incl  = v;
		first = hit & ~(v << 1);
		any   = v[lkvt_pkg::DEPTH-1];
	end

	always_comb begin
		int idx;
		for (int g = 0; g < lkvt_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < lkvt_pkg::GRP; j++) begin
				idx = g * lkvt_pkg::GRP + j;
				if (idx < lkvt_pkg::DEPTH) begin
					if (first[idx]) begin
						grp_d[g] = grp_d[g] | values[idx];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_q <= grp_d;
			any_q <= any;
		end
	end

	always_comb begin
		found = '0;
		for (int g = 0; g < lkvt_pkg::NGRP; g++) begin
			found = found | grp_q[g];
		end
	end

endmodule

// ===== src/lkvt_checker.sv =====
// Port-level checker for the linear key/value table unit, bound to the top level.
// Depends on linear_key_value_table_unit_macros.svh and lkvt_pkg.
`include "linear_key_value_table_unit_macros.svh"

module lkvt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [1:0]                   status,
	input logic [lkvt_pkg::FIELD_W-1:0] found_value,
	input logic [lkvt_pkg::ENTRY_W-1:0] entry_count
);

	`LKVT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "Accepted word did not raise busy.")
	`LKVT_ASSERT_NXT(a_no_instant_done, start && !busy, !done, "Result word one cycle after accept.")
	`LKVT_ASSERT_IMP(a_done_idle, done, !busy, "Result word shown while busy.")
	`LKVT_ASSERT_IMP(a_found_zero, done && (status != lkvt_pkg::ST_OK), found_value == '0, "Nonzero value on failed command.")
	`LKVT_ASSERT_IMP(a_count_range, done, entry_count <= lkvt_pkg::ENTRY_W'(lkvt_pkg::DEPTH), "Entry count beyond table depth.")

endmodule

bind linear_key_value_table_unit lkvt_checker u_lkvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_value (found_value),
	.entry_count (entry_count)
);

// ===== dv/tb_linear_key_value_table_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_key_value_table_unit: a queued command driver, a result
// monitor and an in-bench table predictor that checks status, found_value and entry_count.
// Depends on lkvt_pkg and the unit's RTL only.

module tb_linear_key_value_table_unit;

	localparam int RANDOM_WORDS = 490;
	localparam int FILL_PUTS    = 132;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int POOL_SIZE    = 12;

	typedef struct {
		lkvt_pkg::op_t                op;
		logic [lkvt_pkg::FIELD_W-1:0] key;
		logic [lkvt_pkg::FIELD_W-1:0] value;
	} table_cmd_t;

	typedef struct {
		lkvt_pkg::status_t            status;
		logic [lkvt_pkg::FIELD_W-1:0] found;
		logic [lkvt_pkg::ENTRY_W-1:0] count;
	} table_reply_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         start      = 1'b0;
	logic [1:0]                   op         = lkvt_pkg::OP_PUT;
	logic [lkvt_pkg::FIELD_W-1:0] key_word   = '0;
	logic [lkvt_pkg::FIELD_W-1:0] value_word = '0;
	logic                         busy;
	logic                         done;
	logic [1:0]                   status;
	logic [lkvt_pkg::FIELD_W-1:0] found_value;
	logic [lkvt_pkg::ENTRY_W-1:0] entry_count;

	linear_key_value_table_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.key_word    (key_word),
		.value_word  (value_word),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.entry_count (entry_count)
	);

	logic [lkvt_pkg::WORD_BITS-1:0] table_keys   [lkvt_pkg::DEPTH];
	logic [lkvt_pkg::WORD_BITS-1:0] table_values [lkvt_pkg::DEPTH];
	int                             table_fill = 0;

	table_cmd_t   queued_commands [$];
	table_reply_t pending_replies [$];
	logic [lkvt_pkg::FIELD_W-1:0] key_pool [POOL_SIZE];

	table_cmd_t presented;
	bit         holding        = 1'b0;
	int         gap_left       = 0;
	int         accepted_words = 0;
	int         op_seen [4]    = '{0, 0, 0, 0};
	int         full_replies   = 0;
	int         miss_replies   = 0;
	int         peak_fill      = 0;
	int         mismatch_count = 0;
	int         cycle_count    = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic table_reply_t apply_table_command(table_cmd_t c);
		table_reply_t r;
		int           pos;
		r.status = lkvt_pkg::ST_OK;
		r.found  = '0;
		pos      = table_fill;
		for (int i = table_fill - 1; i >= 0; i--) begin
			if (table_keys[i] == c.key[lkvt_pkg::WORD_BITS-1:0])
				pos = i;
		end
		case (c.op)
			lkvt_pkg::OP_PUT: begin
				if (table_fill < lkvt_pkg::DEPTH) begin
					table_keys[table_fill]   = c.key[lkvt_pkg::WORD_BITS-1:0];
					table_values[table_fill] = c.value[lkvt_pkg::WORD_BITS-1:0];
					table_fill++;
				end else begin
					r.status = lkvt_pkg::ST_FULL;
				end
			end
			lkvt_pkg::OP_GET: begin
				if (pos < table_fill)
					r.found = table_values[pos];
				else
					r.status = lkvt_pkg::ST_NOT_FOUND;
			end
			lkvt_pkg::OP_DELETE: begin
				if (pos < table_fill) begin
					for (int j = pos; j + 1 < table_fill; j++) begin
						table_keys[j]   = table_keys[j + 1];
						table_values[j] = table_values[j + 1];
					end
					table_fill--;
				end else begin
					r.status = lkvt_pkg::ST_NOT_FOUND;
				end
			end
			default: table_fill = 0;
		endcase
		r.count = table_fill[lkvt_pkg::ENTRY_W-1:0];
		return r;
	endfunction

	function automatic logic [lkvt_pkg::FIELD_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic table_cmd_t make_cmd(lkvt_pkg::op_t o,
			logic [lkvt_pkg::FIELD_W-1:0] k, logic [lkvt_pkg::FIELD_W-1:0] v);
		table_cmd_t c;
		c.op    = o;
		c.key   = k;
		c.value = v;
		return c;
	endfunction

	function automatic logic [lkvt_pkg::FIELD_W-1:0] pick_key();
		if ($urandom_range(99) < 75)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return random_word();
	endfunction

	function automatic table_cmd_t random_table_command();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return make_cmd(lkvt_pkg::OP_PUT, pick_key(), random_word());
		if (roll < 73)
			return make_cmd(lkvt_pkg::OP_GET, pick_key(), random_word());
		if (roll < 99)
			return make_cmd(lkvt_pkg::OP_DELETE, pick_key(), random_word());
		return make_cmd(lkvt_pkg::OP_CLEAR, pick_key(), random_word());
	endfunction

	task automatic report_mismatch(input string what, input logic [lkvt_pkg::FIELD_W-1:0] got,
			input logic [lkvt_pkg::FIELD_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				pending_replies.push_back(apply_table_command(presented));
				op_seen[presented.op]++;
				if (pending_replies[$].status == lkvt_pkg::ST_FULL)
					full_replies++;
				if (pending_replies[$].status == lkvt_pkg::ST_NOT_FOUND)
					miss_replies++;
				if (table_fill > peak_fill)
					peak_fill = table_fill;
				accepted_words++;
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (queued_commands.size() != 0) begin
					if ((accepted_words < 250 || accepted_words >= 450) &&
							$urandom_range(99) < 12) begin
						gap_left = $urandom_range(0, 5);
					end else begin
						presented = queued_commands.pop_front();
						holding   = 1'b1;
					end
				end
			end
			start      <= holding;
			op         <= presented.op;
			key_word   <= presented.key;
			value_word <= presented.value;
		end
	end

	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("word with nothing pending", {62'd0, status}, '0);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", {62'd0, status}, {62'd0, want.status});
				if (found_value !== want.found)
					report_mismatch("found_value", found_value, want.found);
				if (entry_count !== want.count)
					report_mismatch("entry_count", {56'd0, entry_count}, {56'd0, want.count});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words accepted", cycle_count, accepted_words);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = {(lkvt_pkg::FIELD_W/2){2'b10}};
		key_pool[3] = {(lkvt_pkg::FIELD_W/2){2'b01}};
		key_pool[4] = 64'd1;
		key_pool[5] = 64'h8000_0000_0000_0000;
		for (int i = 6; i < POOL_SIZE; i++)
			key_pool[i] = random_word();

		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[0], '1));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_CLEAR, '1, '1));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[0], '1));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[1], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[4], random_word()));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[0], 64'h1234));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[1], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[5], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[5], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[1], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[4], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_CLEAR, '0, '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[2], key_pool[3]));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[2], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[3], key_pool[2]));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[2], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[3], '0));

		// Run the table past full, then work on it while it holds every entry.
		for (int i = 0; i < FILL_PUTS; i++)
			queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, pick_key(), random_word()));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_GET, key_pool[1], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_DELETE, key_pool[0], '0));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[2], random_word()));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_PUT, key_pool[3], random_word()));
		queued_commands.push_back(make_cmd(lkvt_pkg::OP_CLEAR, '0, '0));

		for (int i = 0; i < RANDOM_WORDS; i++)
			queued_commands.push_back(random_table_command());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (queued_commands.size() != 0 || holding || pending_replies.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d words: %0d put, %0d get, %0d delete, %0d clear.",
			accepted_words, op_seen[lkvt_pkg::OP_PUT], op_seen[lkvt_pkg::OP_GET],
			op_seen[lkvt_pkg::OP_DELETE], op_seen[lkvt_pkg::OP_CLEAR]);
		$display("Saw %0d full and %0d not-found replies, peak fill %0d, %0d mismatches.",
			full_replies, miss_replies, peak_fill, mismatch_count);
		if (mismatch_count == 0 && pending_replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
